/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a low-active reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AABB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define AABB_NEVER(lbl, clk, rst_n, expr, msg) \
    `AABB_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

/* sv/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// Item types, field widths and codes of the box collision checker.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

    localparam int ID_W    = 6;    // entity index field
    localparam int KIND_W  = 2;
    localparam int CW      = 32;   // Q16.16 coordinate field
    localparam int SIZE_W  = 31;   // UQ15.16 box size field
    localparam int DT_W    = 20;   // Q4.16 frame time
    localparam int FRAC_W  = 16;
    localparam int MAX_RES = 64;   // results per query
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] SIDE_NORTH = 2'd0;
    localparam logic [1:0] SIDE_SOUTH = 2'd1;
    localparam logic [1:0] SIDE_WEST  = 2'd2;
    localparam logic [1:0] SIDE_EAST  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [ID_W-1:0]          entry_index;
        logic signed [CW-1:0]     pos_x;
        logic signed [CW-1:0]     pos_y;
        logic signed [CW-1:0]     vel_x;
        logic signed [CW-1:0]     vel_y;
        logic [DT_W-1:0]          step_time;
        logic signed [CW-1:0]     box_left;
        logic signed [CW-1:0]     box_top;
        logic [SIZE_W-1:0]        box_width;
        logic [SIZE_W-1:0]        box_height;
    } t_in_item;

    typedef struct packed {
        logic                     hit;
        logic [ID_W-1:0]          self_id;
        logic [ID_W-1:0]          other_id;
        logic [1:0]               contact_side;
        logic signed [CW-1:0]     overlap_left;
        logic signed [CW-1:0]     overlap_top;
        logic [SIZE_W-1:0]        overlap_width;
        logic [SIZE_W-1:0]        overlap_height;
        logic                     last;
    } t_out_item;

    // tag of an entry read entering the compare pipe
    typedef struct packed {
        logic tok;    // slot carries an entry
        logic last;   // final entry of the sweep
        logic self;   // entry is the querying entity
    } t_cmp_ctl;

    // status of an entry leaving the compare pipe
    typedef struct packed {
        logic       tok;
        logic       last;
        logic       hit;
        logic [1:0] side;
    } t_cmp_flag;

endpackage

`default_nettype wire

/* sv/aabb_if.sv */
// ----------------------------------------------------------------------------
// aabb_if
// Valid/ready stream channels for request and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabb_in_if;
    import aabb_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aabb_out_if;
    import aabb_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/aabb_sweep_collision_check.sv */
// ----------------------------------------------------------------------------
// aabb_sweep_collision_check
// Entity box table with swept-box overlap query and contact side report.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake            carries
//   i_in      in    valid/ready (sink)   write, remove or query request
//   o_out     out   valid/ready (source) collision record or no-hit record
//
// Writes and removes write the table at the transfer.
// A query runs multiply, move and edges ahead of the sweep, then one table
// read per entry out of the single box memory, then read, compare and flush
// behind it. Every hit beyond the first, up to the per-query limit, waits
// while o_out is full.
// After reset the box memory is cleared, one entry a cycle; i_in is not
// ready until that pass is done.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module aabb_sweep_collision_check #(
    parameter int ENTRIES    = 64,
    parameter int COORD_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    aabb_in_if.sink    i_in,
    aabb_out_if.source o_out
);
    import aabb_pkg::*;

    // ---------------------------------------------------------------- sizes
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // wide enough for both index fields and for ENTRIES itself
    localparam int CMPW   = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
    localparam int EW     = ((COORD_BITS > CW) ? COORD_BITS : CW) + 2;
    localparam int PROD_W = CW + DT_W + 1;
    localparam int DISP_W = PROD_W - FRAC_W;
    localparam int SUMW   = ((COORD_BITS > DISP_W) ? COORD_BITS : DISP_W) + 3;

    localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CMPW-1:0]        NUM_ENT  = CMPW'(ENTRIES);
    localparam logic signed [SUMW-1:0] SAT_HI   = (SUMW'(1) <<< (COORD_BITS - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SAT_LO   = ~SAT_HI;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [CNT_W-1:0]       CNT_FULL = CNT_W'(MAX_RES);

    // --------------------------------------------------------------- states
    localparam logic [2:0] S_CLEAR = 3'd0;   // memory clearing pass
    localparam logic [2:0] S_IDLE  = 3'd1;   // take requests
    localparam logic [2:0] S_MOVE  = 3'd2;   // moved corner, saturated
    localparam logic [2:0] S_EDGE  = 3'd3;   // right/bottom edges, centres
    localparam logic [2:0] S_SCAN  = 3'd4;   // sweep the table
    localparam logic [2:0] S_FLUSH = 3'd5;   // final record out

    typedef struct packed {
        logic                         vld;
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [SIZE_W-1:0]            width;
        logic [SIZE_W-1:0]            height;
    } t_entry;

    function automatic logic signed [COORD_BITS-1:0] f_sat(input logic signed [SUMW-1:0] v);
        if (v > SAT_HI) begin
            f_sat = COORD_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            f_sat = COORD_BITS'(SAT_LO);
        end else begin
            f_sat = COORD_BITS'(v);
        end
    endfunction

    // ------------------------------------------------------------- signals
    t_entry                       r_mem [ENTRIES];
    logic [2:0]                   r_state;
    logic [IDX_W-1:0]             r_clr;

    // request side
    logic                         w_acc;
    logic                         w_idx_ok;
    logic [IDX_W-1:0]             w_waddr;
    logic                         w_we;
    t_entry                       w_wdata;
    logic signed [SUMW-1:0]       w_wr_sx, w_wr_sy;
    logic signed [PROD_W-1:0]     w_prod_x, w_prod_y;

    // query box
    logic [ID_W-1:0]              r_self;
    logic signed [CW-1:0]         r_bl, r_bt, r_px, r_py;
    logic [SIZE_W-1:0]            r_bw, r_bh;
    logic signed [PROD_W-1:0]     r_prod_x, r_prod_y;
    logic signed [PROD_W-1:0]     w_rnd_x, w_rnd_y;
    logic signed [DISP_W-1:0]     w_disp_x, w_disp_y;
    logic signed [SUMW-1:0]       w_mv_x, w_mv_y;
    logic signed [COORD_BITS-1:0] r_nl, r_nt;
    logic signed [EW-1:0]         w_bw_e, w_bh_e;
    logic signed [EW-1:0]         r_nr, r_nb, r_ncx2, r_ncy2;

    // sweep
    logic                         r_iss;
    logic [IDX_W-1:0]             r_rd_addr;
    t_entry                       r_q;
    t_cmp_ctl                     r_q_ctl;
    logic [IDX_W-1:0]             r_q_idx;
    t_cmp_flag                    w_flag;
    logic [IDX_W-1:0]             w_c_idx;
    logic signed [CW-1:0]         w_c_x, w_c_y;
    logic [SIZE_W-1:0]            w_c_w, w_c_h;

    // result side: one hit held back until its successor shows whether it is last
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_pend_vld;
    t_out_item                    r_pend;
    logic                         r_out_vld;
    t_out_item                    r_out;
    logic                         w_out_free;
    logic                         w_room;
    logic                         w_stall;
    logic                         w_adv;
    logic                         w_take;
    logic                         w_out_load;
    t_out_item                    w_new;
    t_out_item                    w_out_data;

    // ----------------------------------------------------------- requests
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_idx_ok   = CMPW'(i_in.data.entry_index) < NUM_ENT;
    assign w_waddr    = IDX_W'(i_in.data.entry_index);
    assign w_wr_sx    = SUMW'(i_in.data.box_left) + SUMW'(i_in.data.pos_x);
    assign w_wr_sy    = SUMW'(i_in.data.box_top) + SUMW'(i_in.data.pos_y);
    // velocity times frame time, exact Q21.32
    assign w_prod_x   = i_in.data.vel_x * $signed({1'b0, i_in.data.step_time});
    assign w_prod_y   = i_in.data.vel_y * $signed({1'b0, i_in.data.step_time});

    // table write port: clearing pass, box write or remove
    always_comb begin
        w_we    = 1'b0;
        w_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (w_acc && w_idx_ok) begin
            if (i_in.data.kind == KIND_WRITE) begin
                w_we           = 1'b1;
                w_wdata.vld    = 1'b1;
                w_wdata.left   = f_sat(w_wr_sx);
                w_wdata.top    = f_sat(w_wr_sy);
                w_wdata.width  = i_in.data.box_width;
                w_wdata.height = i_in.data.box_height;
            end else if (i_in.data.kind == KIND_REMOVE) begin
                w_we = 1'b1;   // valid cleared, box left as don't care
            end
        end
    end

    // writes happen only in IDLE or CLEAR, reads only in SCAN: no overlap
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[(r_state == S_CLEAR) ? r_clr : w_waddr] <= w_wdata;
        end
        if (w_adv && r_iss) begin
            r_q     <= r_mem[r_rd_addr];
            r_q_idx <= r_rd_addr;
        end
    end

    // ---------------------------------------------------------- query box
    // displacement rounded half up to Q21.16
    assign w_rnd_x  = r_prod_x + RND_HALF;
    assign w_rnd_y  = r_prod_y + RND_HALF;
    assign w_disp_x = w_rnd_x[PROD_W-1:FRAC_W];
    assign w_disp_y = w_rnd_y[PROD_W-1:FRAC_W];
    assign w_mv_x   = SUMW'(r_bl) + SUMW'(r_px) + SUMW'(w_disp_x);
    assign w_mv_y   = SUMW'(r_bt) + SUMW'(r_py) + SUMW'(w_disp_y);
    assign w_bw_e   = $signed(EW'(r_bw));
    assign w_bh_e   = $signed(EW'(r_bh));

    // ------------------------------------------------------------ compare
    aabb_cmp #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_cmp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_ctl        (r_q_ctl),
        .i_idx        (r_q_idx),
        .i_ent_vld    (r_q.vld),
        .i_ent_left   (r_q.left),
        .i_ent_top    (r_q.top),
        .i_ent_width  (r_q.width),
        .i_ent_height (r_q.height),
        .i_nl         (r_nl),
        .i_nt         (r_nt),
        .i_nr         (r_nr),
        .i_nb         (r_nb),
        .i_ncx2       (r_ncx2),
        .i_ncy2       (r_ncy2),
        .o_flag       (w_flag),
        .o_idx        (w_c_idx),
        .o_x          (w_c_x),
        .o_y          (w_c_y),
        .o_w          (w_c_w),
        .o_h          (w_c_h)
    );

    // ------------------------------------------------------------ results
    assign w_out_free = !r_out_vld || o_out.ready;
    // hits past the per-query limit are dropped, the sweep still runs out
    assign w_room     = (r_cnt != CNT_FULL);
    // a new hit needs the held one moved to o_out first
    assign w_stall    = w_flag.hit && w_room && r_pend_vld && !w_out_free;
    assign w_adv      = !w_stall;
    assign w_take     = w_flag.hit && w_room && !w_stall;
    assign w_out_load = (w_take && r_pend_vld) || ((r_state == S_FLUSH) && w_out_free);

    always_comb begin
        w_new                = '0;
        w_new.hit            = 1'b1;
        w_new.self_id        = r_self;
        w_new.other_id       = ID_W'(CMPW'(w_c_idx));
        w_new.contact_side   = w_flag.side;
        w_new.overlap_left   = w_c_x;
        w_new.overlap_top    = w_c_y;
        w_new.overlap_width  = w_c_w;
        w_new.overlap_height = w_c_h;
    end

    always_comb begin
        w_out_data      = r_pend;
        w_out_data.last = 1'b0;
        if (r_state == S_FLUSH) begin
            if (r_pend_vld) begin
                w_out_data.last = 1'b1;
            end else begin
                w_out_data         = '0;
                w_out_data.self_id = r_self;
                w_out_data.last    = 1'b1;
            end
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // -------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_iss      <= 1'b0;
            r_q_ctl    <= '0;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_clr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_acc && (i_in.data.kind == KIND_QUERY)) begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_state <= S_SCAN;
                    r_iss   <= 1'b1;
                    r_cnt   <= '0;
                end
                S_SCAN: begin
                    if (w_adv && w_flag.tok && w_flag.last) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // read issue, one entry a cycle while the pipe moves
            if (w_adv) begin
                r_q_ctl.tok  <= r_iss;
                r_q_ctl.last <= (r_rd_addr == LAST_IDX);
                r_q_ctl.self <= (CMPW'(r_rd_addr) == CMPW'(r_self));
                if (r_iss && (r_rd_addr == LAST_IDX)) begin
                    r_iss <= 1'b0;
                end
            end

            if (w_take) begin
                r_pend_vld <= 1'b1;
                r_cnt      <= r_cnt + 1'b1;
            end else if ((r_state == S_FLUSH) && w_out_free) begin
                r_pend_vld <= 1'b0;
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------- payload regs
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_self   <= i_in.data.entry_index;
            r_bl     <= i_in.data.box_left;
            r_bt     <= i_in.data.box_top;
            r_px     <= i_in.data.pos_x;
            r_py     <= i_in.data.pos_y;
            r_bw     <= i_in.data.box_width;
            r_bh     <= i_in.data.box_height;
            r_prod_x <= w_prod_x;
            r_prod_y <= w_prod_y;
        end
        if (r_state == S_MOVE) begin
            r_nl <= f_sat(w_mv_x);
            r_nt <= f_sat(w_mv_y);
        end
        if (r_state == S_EDGE) begin
            r_nr      <= EW'(r_nl) + w_bw_e;
            r_nb      <= EW'(r_nt) + w_bh_e;
            r_ncx2    <= (EW'(r_nl) <<< 1) + w_bw_e;
            r_ncy2    <= (EW'(r_nt) <<< 1) + w_bh_e;
            r_rd_addr <= '0;
        end else if (w_adv && r_iss && (r_rd_addr != LAST_IDX)) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (w_take) begin
            r_pend <= w_new;
        end
        if (w_out_load) begin
            r_out <= w_out_data;
        end
    end

    // ---------------------------------------------------------- assertions
    `AABB_ASSERT(a_pend_counted, i_clk, i_rst_n, r_pend_vld |-> (r_cnt != '0), "held hit not counted")
    `AABB_NEVER(a_cnt_limit, i_clk, i_rst_n, r_cnt > CNT_FULL, "hit count past limit")
    `AABB_ASSERT(a_nohit_last, i_clk, i_rst_n, (o_out.valid && !o_out.data.hit) |-> o_out.data.last, "no-hit record not last")
    `AABB_ASSERT(a_flush_out, i_clk, i_rst_n, ((r_state == S_FLUSH) && w_out_free) |=> (r_out_vld && r_out.last && (r_state == S_IDLE)), "query end without final record")
    `AABB_NEVER(a_stall_scan, i_clk, i_rst_n, w_stall && (r_state != S_SCAN), "stall outside sweep")

endmodule

`default_nettype wire

/* sv/aabb_cmp.sv */
// ----------------------------------------------------------------------------
// aabb_cmp
// Two-stage overlap test of one stored box against the moved query box.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_cmp #(
    parameter int  COORD_BITS = 32,
    parameter int  IDX_W      = 6,
    localparam int EW         = ((COORD_BITS > aabb_pkg::CW) ? COORD_BITS : aabb_pkg::CW) + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  aabb_pkg::t_cmp_ctl            i_ctl,
    input  logic [IDX_W-1:0]              i_idx,
    input  logic                          i_ent_vld,
    input  logic signed [COORD_BITS-1:0]  i_ent_left,
    input  logic signed [COORD_BITS-1:0]  i_ent_top,
    input  logic [aabb_pkg::SIZE_W-1:0]   i_ent_width,
    input  logic [aabb_pkg::SIZE_W-1:0]   i_ent_height,
    input  logic signed [COORD_BITS-1:0]  i_nl,
    input  logic signed [COORD_BITS-1:0]  i_nt,
    input  logic signed [EW-1:0]          i_nr,
    input  logic signed [EW-1:0]          i_nb,
    input  logic signed [EW-1:0]          i_ncx2,
    input  logic signed [EW-1:0]          i_ncy2,
    output aabb_pkg::t_cmp_flag           o_flag,
    output logic [IDX_W-1:0]              o_idx,
    output logic signed [aabb_pkg::CW-1:0] o_x,
    output logic signed [aabb_pkg::CW-1:0] o_y,
    output logic [aabb_pkg::SIZE_W-1:0]   o_w,
    output logic [aabb_pkg::SIZE_W-1:0]   o_h
);
    import aabb_pkg::*;

    // stage 1: edges, overlap corner, centre order
    logic signed [EW-1:0] w_ol, w_ot, w_ow, w_oh, w_nl, w_nt;
    logic signed [EW-1:0] w_orr, w_ob, w_ocx2, w_ocy2;

    logic                 r1_tok, r1_last, r1_cand;
    logic [IDX_W-1:0]     r1_idx;
    logic signed [EW-1:0] r1_x, r1_y, r1_rmin, r1_bmin;
    logic                 r1_ns, r1_we;

    // stage 2: extents and side
    logic signed [EW-1:0] w_w, w_h;
    logic                 w_hit;
    logic [1:0]           w_side;

    assign w_ol   = EW'(i_ent_left);
    assign w_ot   = EW'(i_ent_top);
    assign w_ow   = $signed(EW'(i_ent_width));
    assign w_oh   = $signed(EW'(i_ent_height));
    assign w_nl   = EW'(i_nl);
    assign w_nt   = EW'(i_nt);
    assign w_orr  = w_ol + w_ow;
    assign w_ob   = w_ot + w_oh;
    assign w_ocx2 = (w_ol <<< 1) + w_ow;
    assign w_ocy2 = (w_ot <<< 1) + w_oh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tok  <= 1'b0;
            r1_last <= 1'b0;
            r1_cand <= 1'b0;
        end else if (i_adv) begin
            r1_tok  <= i_ctl.tok;
            r1_last <= i_ctl.last;
            r1_cand <= i_ctl.tok && i_ent_vld && !i_ctl.self;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_idx  <= i_idx;
            r1_x    <= (w_nl > w_ol) ? w_nl : w_ol;
            r1_y    <= (w_nt > w_ot) ? w_nt : w_ot;
            r1_rmin <= (i_nr < w_orr) ? i_nr : w_orr;
            r1_bmin <= (i_nb < w_ob) ? i_nb : w_ob;
            r1_ns   <= (w_ocy2 >= i_ncy2);
            r1_we   <= (w_ocx2 >= i_ncx2);
        end
    end

    assign w_w   = r1_rmin - r1_x;
    assign w_h   = r1_bmin - r1_y;
    assign w_hit = r1_cand && (w_w > 0) && (w_h > 0);

    always_comb begin
        if (w_w > w_h) begin
            w_side = r1_ns ? SIDE_NORTH : SIDE_SOUTH;
        end else begin
            w_side = r1_we ? SIDE_WEST : SIDE_EAST;
        end
    end

    assign o_flag.tok  = r1_tok;
    assign o_flag.last = r1_last;
    assign o_flag.hit  = w_hit;
    assign o_flag.side = w_side;
    assign o_idx       = r1_idx;
    assign o_x         = CW'(r1_x);
    assign o_y         = CW'(r1_y);
    assign o_w         = SIZE_W'(w_w);
    assign o_h         = SIZE_W'(w_h);

endmodule

`default_nettype wire
